// ----- rtl/wpc_pkg.sv -----
package wpc_pkg;

  // sample and window sizing
  localparam int SAMPLE_W    = 16;
  localparam int MAX_WINDOW  = 16384;
  localparam int CNT_W       = 15;
  localparam int SUM_W       = 31;
  localparam int SQ_W        = 45;
  localparam int XP_W        = 46;

  // back-end arithmetic widths
  localparam int TERM_W      = 64;
  localparam int PROD_W      = 2 * TERM_W;
  localparam int DIGIT_W     = 16;
  localparam int DIGITS      = TERM_W / DIGIT_W;
  localparam int DIGIT_IDX_W = $clog2(DIGITS);
  localparam int PP_W        = TERM_W + DIGIT_W;
  localparam int SRCH_W      = 160;

  // result format
  localparam int COEF_W      = 16;
  localparam int Q_FRAC      = COEF_W - 1;
  localparam int M_W         = Q_FRAC + 1;
  localparam int BIT_IDX_W   = $clog2(M_W);
  localparam int SRCH_B_SH   = Q_FRAC + 2;
  localparam int SRCH_P_SH   = 2 * Q_FRAC + 2;
  localparam int SRCH_T_SH   = 2 * DIGIT_W;
  localparam int VAL_W       = COEF_W + 2;
  localparam int COEF_ONE    = 32768;
  localparam int COEF_MAX    = 32767;
  localparam int COEF_MIN    = -32768;

  // window queue
  localparam int QUEUE_DEPTH = 2;

  // closed window handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic [SQ_W-1:0]         sxx;
    logic [SQ_W-1:0]         syy;
    logic signed [XP_W-1:0]  sxy;
  } window_t;

  // products formed by the shared multiplier, in order
  typedef enum logic [2:0] {
    OP_N_XY  = 3'd0,
    OP_X_Y   = 3'd1,
    OP_N_XX  = 3'd2,
    OP_X_X   = 3'd3,
    OP_N_YY  = 3'd4,
    OP_Y_Y   = 3'd5,
    OP_VX_VY = 3'd6,
    OP_C_C   = 3'd7
  } mul_op_t;

  // magnitude of a signed term
  function automatic logic [TERM_W-1:0] term_mag(input logic signed [TERM_W-1:0] v);
    logic [TERM_W-1:0] r;
    r = v[TERM_W-1] ? $unsigned(-v) : $unsigned(v);
    return r;
  endfunction

endpackage

// ----- rtl/wpc_if.sv -----
interface wpc_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wpc_pkg::SAMPLE_W-1:0]  sample_x;
  logic signed [wpc_pkg::SAMPLE_W-1:0]  sample_y;
  logic                                 last_sample;

  modport source (output valid, sample_x, sample_y, last_sample, input ready);
  modport sink   (input valid, sample_x, sample_y, last_sample, output ready);
endinterface

interface wpc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [wpc_pkg::COEF_W-1:0]  coefficient;
  logic                               invalid_flag;
  logic [wpc_pkg::CNT_W-1:0]          window_count;

  modport source (output valid, coefficient, invalid_flag, window_count, input ready);
  modport sink   (input valid, coefficient, invalid_flag, window_count, output ready);
endinterface

// ----- rtl/wpc_front.sv -----
module wpc_front (
  input  logic             clk,
  input  logic             rst,
  wpc_sample_if.sink       samples,
  output logic             push_valid,
  input  logic             push_ready,
  output wpc_pkg::window_t push_data
);

  logic [wpc_pkg::CNT_W-1:0]         pair_count;
  logic signed [wpc_pkg::SUM_W-1:0]  sum_first;
  logic signed [wpc_pkg::SUM_W-1:0]  sum_second;
  logic [wpc_pkg::SQ_W-1:0]          sum_first_squared;
  logic [wpc_pkg::SQ_W-1:0]          sum_second_squared;
  logic signed [wpc_pkg::XP_W-1:0]   sum_cross_product;

  logic [wpc_pkg::CNT_W-1:0]         pair_count_next;
  logic signed [wpc_pkg::SUM_W-1:0]  sum_first_next;
  logic signed [wpc_pkg::SUM_W-1:0]  sum_second_next;
  logic [wpc_pkg::SQ_W-1:0]          sum_first_squared_next;
  logic [wpc_pkg::SQ_W-1:0]          sum_second_squared_next;
  logic signed [wpc_pkg::XP_W-1:0]   sum_cross_product_next;

  logic signed [2*wpc_pkg::SAMPLE_W-1:0] prod_xx;
  logic signed [2*wpc_pkg::SAMPLE_W-1:0] prod_yy;
  logic signed [2*wpc_pkg::SAMPLE_W-1:0] prod_xy;
  logic accept;
  logic close;

  // a word is taken whenever the queue has room for a closing window
  assign samples.ready = push_ready;
  assign accept        = samples.valid & samples.ready;

  // per-pair products
  assign prod_xx = samples.sample_x * samples.sample_x;
  assign prod_yy = samples.sample_y * samples.sample_y;
  assign prod_xy = samples.sample_x * samples.sample_y;

  // running sums including the current pair
  assign pair_count_next         = pair_count + 1'b1;
  assign sum_first_next          = sum_first + wpc_pkg::SUM_W'(samples.sample_x);
  assign sum_second_next         = sum_second + wpc_pkg::SUM_W'(samples.sample_y);
  assign sum_first_squared_next  = sum_first_squared + wpc_pkg::SQ_W'($unsigned(prod_xx));
  assign sum_second_squared_next = sum_second_squared + wpc_pkg::SQ_W'($unsigned(prod_yy));
  assign sum_cross_product_next  = sum_cross_product + wpc_pkg::XP_W'(prod_xy);

  // window closes on the last flag or when full
  assign close = samples.last_sample |
                 (pair_count_next == wpc_pkg::CNT_W'(wpc_pkg::MAX_WINDOW));

  assign push_valid = accept & close;
  assign push_data  = '{n:   pair_count_next,
                        sx:  sum_first_next,
                        sy:  sum_second_next,
                        sxx: sum_first_squared_next,
                        syy: sum_second_squared_next,
                        sxy: sum_cross_product_next};

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count         <= '0;
      sum_first          <= '0;
      sum_second         <= '0;
      sum_first_squared  <= '0;
      sum_second_squared <= '0;
      sum_cross_product  <= '0;
    end else if (accept) begin
      if (close) begin
        pair_count         <= '0;
        sum_first          <= '0;
        sum_second         <= '0;
        sum_first_squared  <= '0;
        sum_second_squared <= '0;
        sum_cross_product  <= '0;
      end else begin
        pair_count         <= pair_count_next;
        sum_first          <= sum_first_next;
        sum_second         <= sum_second_next;
        sum_first_squared  <= sum_first_squared_next;
        sum_second_squared <= sum_second_squared_next;
        sum_cross_product  <= sum_cross_product_next;
      end
    end
  end

`ifndef ASSERT_OFF
  // an open window never reaches the full size
  a_count_below_max: assert property (@(posedge clk) disable iff (rst)
    pair_count < wpc_pkg::CNT_W'(wpc_pkg::MAX_WINDOW))
    else $error("open window reached full size");
`endif

endmodule

// ----- rtl/wpc_queue.sv -----
module wpc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  wpc_pkg::window_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output wpc_pkg::window_t pop_data
);

  localparam int PTR_W = $clog2(wpc_pkg::QUEUE_DEPTH);
  localparam int FILL_W = $clog2(wpc_pkg::QUEUE_DEPTH + 1);

  wpc_pkg::window_t entries [wpc_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic push;
  logic pop;

  assign push_ready = fill != FILL_W'(wpc_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = entries[rd_ptr];

  // window storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push & ~pop) begin
        fill <= fill + 1'b1;
      end else if (pop & ~push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/wpc_back.sv -----
module wpc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  wpc_pkg::window_t pop_data,
  input  logic             output_mode,
  wpc_result_if.source     results
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_LOAD   = 6'b000010,
    ST_MUL    = 6'b000100,
    ST_STORE  = 6'b001000,
    ST_SEARCH = 6'b010000,
    ST_WRITE  = 6'b100000
  } state_t;

  state_t state;
  wpc_pkg::window_t win;
  wpc_pkg::mul_op_t op;

  // shared multiplier
  logic [wpc_pkg::TERM_W-1:0]      mul_a;
  logic [wpc_pkg::TERM_W-1:0]      mul_b;
  logic                            mul_neg;
  logic [wpc_pkg::PROD_W-1:0]      acc;
  logic [wpc_pkg::DIGIT_IDX_W-1:0] digit;

  // centred terms
  logic signed [wpc_pkg::TERM_W-1:0] t_first;
  logic signed [wpc_pkg::TERM_W-1:0] c_term;
  logic signed [wpc_pkg::TERM_W-1:0] vx;
  logic [wpc_pkg::PROD_W-1:0]        p_prod;

  // root search
  logic [wpc_pkg::SRCH_W-1:0]        srch_a;
  logic signed [wpc_pkg::SRCH_W-1:0] srch_bs;
  logic [wpc_pkg::SRCH_W-1:0]        srch_ps;
  logic [wpc_pkg::SRCH_W-1:0]        srch_t;
  logic [wpc_pkg::M_W-1:0]           m;
  logic [wpc_pkg::BIT_IDX_W-1:0]     bit_idx;
  logic                              res_invalid;

  logic signed [wpc_pkg::TERM_W-1:0] sel_a;
  logic signed [wpc_pkg::TERM_W-1:0] sel_b;
  logic [wpc_pkg::DIGIT_W-1:0]       b_digit;
  logic [wpc_pkg::PP_W-1:0]          pp;
  logic [wpc_pkg::PROD_W-1:0]        pp_shifted;
  logic [wpc_pkg::PROD_W-1:0]        prod;
  logic signed [wpc_pkg::TERM_W-1:0] term;
  logic signed [wpc_pkg::TERM_W-1:0] diff;
  logic [wpc_pkg::SRCH_W-1:0]        trial;
  logic signed [wpc_pkg::SRCH_W-1:0] bs_half;
  logic signed [wpc_pkg::VAL_W-1:0]  q_val;
  logic signed [wpc_pkg::VAL_W-1:0]  mode_val;
  logic [wpc_pkg::COEF_W-1:0]        coef_sat;
  logic                              out_free;

  assign pop_ready = state == ST_IDLE;
  assign out_free  = ~results.valid | results.ready;

  // operand selection for the current product
  always_comb begin
    sel_a = '0;
    sel_b = '0;
    unique case (op)
      wpc_pkg::OP_N_XY: begin
        sel_a = wpc_pkg::TERM_W'(win.n);
        sel_b = wpc_pkg::TERM_W'(win.sxy);
      end
      wpc_pkg::OP_X_Y: begin
        sel_a = wpc_pkg::TERM_W'(win.sx);
        sel_b = wpc_pkg::TERM_W'(win.sy);
      end
      wpc_pkg::OP_N_XX: begin
        sel_a = wpc_pkg::TERM_W'(win.n);
        sel_b = wpc_pkg::TERM_W'(win.sxx);
      end
      wpc_pkg::OP_X_X: begin
        sel_a = wpc_pkg::TERM_W'(win.sx);
        sel_b = wpc_pkg::TERM_W'(win.sx);
      end
      wpc_pkg::OP_N_YY: begin
        sel_a = wpc_pkg::TERM_W'(win.n);
        sel_b = wpc_pkg::TERM_W'(win.syy);
      end
      wpc_pkg::OP_Y_Y: begin
        sel_a = wpc_pkg::TERM_W'(win.sy);
        sel_b = wpc_pkg::TERM_W'(win.sy);
      end
      wpc_pkg::OP_VX_VY: begin
        sel_a = vx;
        sel_b = t_first;
      end
      wpc_pkg::OP_C_C: begin
        sel_a = c_term;
        sel_b = c_term;
      end
      default: begin
        sel_a = '0;
        sel_b = '0;
      end
    endcase
  end

  // one 16-bit digit of b per cycle
  assign b_digit    = mul_b[digit * wpc_pkg::DIGIT_W +: wpc_pkg::DIGIT_W];
  assign pp         = mul_a * b_digit;
  assign pp_shifted = wpc_pkg::PROD_W'(pp) << (digit * wpc_pkg::DIGIT_W);
  assign prod       = mul_neg ? (~acc + 1'b1) : acc;
  assign term       = $signed(prod[wpc_pkg::TERM_W-1:0]);
  assign diff       = t_first - term;

  // one bit of the quotient per search step
  assign trial   = srch_a + $unsigned(srch_bs) + srch_ps;
  assign bs_half = srch_bs >>> 1;

  // sign, output mode and saturation
  always_comb begin
    q_val = c_term[wpc_pkg::TERM_W-1] ? -$signed({2'b00, m}) : $signed({2'b00, m});
    mode_val = output_mode ? (wpc_pkg::VAL_W'(wpc_pkg::COEF_ONE) - q_val) : q_val;
    if (mode_val > wpc_pkg::VAL_W'(wpc_pkg::COEF_MAX)) begin
      coef_sat = wpc_pkg::COEF_W'(wpc_pkg::COEF_MAX);
    end else if (mode_val < wpc_pkg::VAL_W'(wpc_pkg::COEF_MIN)) begin
      coef_sat = wpc_pkg::COEF_W'(wpc_pkg::COEF_MIN);
    end else begin
      coef_sat = mode_val[wpc_pkg::COEF_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= wpc_pkg::OP_N_XY;
      digit <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            win         <= pop_data;
            op          <= wpc_pkg::OP_N_XY;
            res_invalid <= 1'b0;
            m           <= '0;
            state       <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mul_a   <= wpc_pkg::term_mag(sel_a);
          mul_b   <= wpc_pkg::term_mag(sel_b);
          mul_neg <= sel_a[wpc_pkg::TERM_W-1] ^ sel_b[wpc_pkg::TERM_W-1];
          acc     <= '0;
          digit   <= '0;
          state   <= ST_MUL;
        end
        ST_MUL: begin
          acc   <= acc + pp_shifted;
          digit <= digit + 1'b1;
          if (digit == wpc_pkg::DIGIT_IDX_W'(wpc_pkg::DIGITS - 1)) begin
            state <= ST_STORE;
          end
        end
        ST_STORE: begin
          op    <= wpc_pkg::mul_op_t'(op + 1'b1);
          state <= ST_LOAD;
          unique case (op)
            wpc_pkg::OP_N_XY, wpc_pkg::OP_N_XX, wpc_pkg::OP_N_YY: begin
              t_first <= term;
            end
            wpc_pkg::OP_X_Y: begin
              c_term <= diff;
            end
            wpc_pkg::OP_X_X: begin
              vx <= diff;
            end
            wpc_pkg::OP_Y_Y: begin
              // vy is parked in t_first for the next product
              t_first <= diff;
              if (vx[wpc_pkg::TERM_W-1] || vx == '0 ||
                  diff[wpc_pkg::TERM_W-1] || diff == '0) begin
                res_invalid <= 1'b1;
                state       <= ST_WRITE;
              end
            end
            wpc_pkg::OP_VX_VY: begin
              p_prod <= prod;
            end
            wpc_pkg::OP_C_C: begin
              srch_a  <= wpc_pkg::SRCH_W'(p_prod);
              srch_bs <= -$signed(wpc_pkg::SRCH_W'(p_prod) << wpc_pkg::SRCH_B_SH);
              srch_ps <= wpc_pkg::SRCH_W'(p_prod) << wpc_pkg::SRCH_P_SH;
              srch_t  <= wpc_pkg::SRCH_W'(prod) << wpc_pkg::SRCH_T_SH;
              bit_idx <= wpc_pkg::BIT_IDX_W'(wpc_pkg::M_W - 1);
              state   <= ST_SEARCH;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_SEARCH: begin
          if (trial <= srch_t) begin
            srch_a     <= trial;
            srch_bs    <= bs_half + $signed(srch_ps);
            m[bit_idx] <= 1'b1;
          end else begin
            srch_bs <= bs_half;
          end
          srch_ps <= srch_ps >> 2;
          if (bit_idx == '0) begin
            state <= ST_WRITE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
          end
        end
        ST_WRITE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == ST_WRITE && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE && out_free) begin
      results.coefficient  <= res_invalid ? '0 : $signed(coef_sat);
      results.invalid_flag <= res_invalid;
      results.window_count <= win.n;
    end
  end

`ifndef ASSERT_OFF
  // invalid windows always carry a zero coefficient
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.invalid_flag |-> results.coefficient == '0)
    else $error("invalid window with nonzero coefficient");

  // the search only runs on a nonzero variance product
  a_search_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> p_prod != '0 && srch_ps != '0)
    else $error("search started on zero variance");

  // a new word never reports an empty window
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> results.window_count != '0)
    else $error("result word with zero pair count");
`endif

endmodule

// ----- rtl/windowed_pearson_correlation.sv -----
// Windowed Pearson correlation: one sample pair accepted per cycle while the window queue has room.
// Each window result is formed by eight products on one shared 64x16 multiplier, taken one
// 16-bit digit at a time, and a 16-step root search (skipped for an invalid window).
// Windows shorter than the back end's work per window are limited by that back end; a two-entry
// window queue lets the front keep accepting meanwhile, until the queue is full.
// Synchronous active-high reset clears the sums, the queue, the sequencer and output_mode.
module windowed_pearson_correlation (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write_en,
  input  logic         cfg_write_data,
  wpc_sample_if.sink   samples,
  wpc_result_if.source results
);

  logic             output_mode;
  logic             push_valid;
  logic             push_ready;
  wpc_pkg::window_t push_data;
  logic             pop_valid;
  logic             pop_ready;
  wpc_pkg::window_t pop_data;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode <= 1'b0;
    end else if (cfg_write_en) begin
      output_mode <= cfg_write_data;
    end
  end

  // accumulation front end
  wpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // closed windows waiting for the back end
  wpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // coefficient back end
  wpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .output_mode (output_mode),
    .results     (results)
  );

endmodule

// ----- verif/wpc_checker.sv -----
module wpc_checker (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_write_en,
  input  logic  cfg_write_data,
  wpc_sample_if samples,
  wpc_result_if results,
  output int    fails,
  output int    pending
);

  typedef struct {
    logic signed [wpc_pkg::COEF_W-1:0] coef;
    logic                              invalid;
    logic [wpc_pkg::CNT_W-1:0]         count;
  } window_result_t;

  window_result_t windows_due[$];

  logic   mode_one;
  longint pairs, sum_x, sum_y, sum_xx, sum_yy, sum_xy;
  int     mismatches;

  // exact correlation of one closed window, rounded to Q1.15
  function automatic window_result_t correlate(longint n, longint sx, longint sy,
                                               longint sxx, longint syy, longint sxy,
                                               logic one_minus);
    logic signed [255:0] wn, wsx, wsy, wsxx, wsyy, wsxy;
    logic signed [255:0] c, vx, vy, p, rhs, lhs, d;
    int lo, hi, m, q, v;
    window_result_t r;
    wn = n; wsx = sx; wsy = sy; wsxx = sxx; wsyy = syy; wsxy = sxy;
    c  = wn * wsxy - wsx * wsy;
    vx = wn * wsxx - wsx * wsx;
    vy = wn * wsyy - wsy * wsy;
    r.count = n[wpc_pkg::CNT_W-1:0];
    if (vx <= 0 || vy <= 0) begin
      r.coef    = '0;
      r.invalid = 1'b1;
      return r;
    end
    p   = vx * vy;
    rhs = (c * c) <<< 32;
    lo  = 0;
    hi  = wpc_pkg::COEF_ONE;
    // largest m with (2m-1)^2 * P <= 2^32 * C^2
    while (lo < hi) begin
      m   = (lo + hi + 1) / 2;
      d   = 2 * m - 1;
      lhs = d * d * p;
      if (lhs <= rhs) lo = m;
      else hi = m - 1;
    end
    q = (c < 0) ? -lo : lo;
    v = one_minus ? wpc_pkg::COEF_ONE - q : q;
    if (v > wpc_pkg::COEF_MAX) v = wpc_pkg::COEF_MAX;
    if (v < wpc_pkg::COEF_MIN) v = wpc_pkg::COEF_MIN;
    r.coef    = v[wpc_pkg::COEF_W-1:0];
    r.invalid = 1'b0;
    return r;
  endfunction

  // follow the sums, predict at window close, compare each result word
  always @(posedge clk) begin
    longint x, y, n;
    window_result_t got, want;
    if (rst) begin
      mode_one <= 1'b0;
      pairs = 0; sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
      windows_due.delete();
      fails      <= 0;
      mismatches = 0;
    end else begin
      if (cfg_write_en) mode_one <= cfg_write_data;
      if (samples.valid && samples.ready) begin
        x = samples.sample_x;
        y = samples.sample_y;
        sum_x += x; sum_y += y;
        sum_xx += x * x; sum_yy += y * y; sum_xy += x * y;
        n = pairs + 1;
        if (samples.last_sample || n >= wpc_pkg::MAX_WINDOW) begin
          windows_due.push_back(correlate(n, sum_x, sum_y, sum_xx, sum_yy, sum_xy,
                                          mode_one));
          pairs = 0; sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
        end else begin
          pairs = n;
        end
      end
      if (results.valid && results.ready) begin
        got.coef    = results.coefficient;
        got.invalid = results.invalid_flag;
        got.count   = results.window_count;
        if (windows_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: coef %0d invalid %0b count %0d",
                     got.coef, got.invalid, got.count);
        end else begin
          want = windows_due.pop_front();
          if (got.coef !== want.coef || got.invalid !== want.invalid ||
              got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected coef %0d invalid %0b count %0d,",
                        " got coef %0d invalid %0b count %0d"},
                       want.coef, want.invalid, want.count,
                       got.coef, got.invalid, got.count);
          end
        end
      end
      fails <= mismatches;
    end
    pending <= windows_due.size();
  end

endmodule

// ----- verif/testbench.sv -----
module testbench;

  typedef enum int {MIX_INDEP, MIX_LINEAR, MIX_FLAT_X, MIX_FLAT_Y} mix_t;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;
  int   fails;
  int   pending;
  int   sent;
  bit   burst;
  bit   squeeze_req;
  bit   squeeze_done;
  int   quiet_cycles;

  wpc_sample_if samples ();
  wpc_result_if results ();

  windowed_pearson_correlation DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .samples        (samples),
    .results        (results)
  );

  wpc_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .samples        (samples),
    .results        (results),
    .fails          (fails),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [wpc_pkg::SAMPLE_W-1:0] clamp16(int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[wpc_pkg::SAMPLE_W-1:0];
  endfunction

  // offer one sample word and hold it until taken
  task automatic send_pair(int x, int y, logic last);
    int g;
    g = burst ? 0 : pick_gap();
    if (g > 0) begin
      samples.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    samples.valid       <= 1'b1;
    samples.sample_x    <= x[wpc_pkg::SAMPLE_W-1:0];
    samples.sample_y    <= y[wpc_pkg::SAMPLE_W-1:0];
    samples.last_sample <= last;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    sent++;
  endtask

  // one window of random content; closed by the last flag unless told otherwise
  task automatic send_window(int len, mix_t mix, bit mark_last);
    int i, x, y, amp, gain, noise, flat;
    amp   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 300) : 32767;
    gain  = $urandom_range(0, 8) - 4;
    noise = $urandom_range(0, 2000);
    flat  = $urandom_range(0, 65535) - 32768;
    for (i = 0; i < len; i++) begin
      x = (amp == 32767) ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 2 * amp) - amp;
      case (mix)
        MIX_INDEP: begin
          y = $urandom_range(0, 65535) - 32768;
        end
        MIX_LINEAR: begin
          y = clamp16((x * gain) / 2 + $urandom_range(0, 2 * noise) - noise);
        end
        MIX_FLAT_X: begin
          y = x;
          x = flat;
        end
        default: begin
          y = flat;
        end
      endcase
      send_pair(x, y, mark_last && (i == len - 1));
    end
  endtask

  task automatic write_mode(logic v);
    samples.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  // short fixed windows covering the corner cases
  task automatic directed_windows();
    send_pair(1234, -77, 1'b1);                 // single pair
    send_pair(500, 3, 1'b0);                    // flat first series
    send_pair(500, -9, 1'b0);
    send_pair(500, 40, 1'b1);
    send_pair(32767, 32767, 1'b0);              // exact positive correlation
    send_pair(-32768, -32768, 1'b0);
    send_pair(0, 0, 1'b1);
    send_pair(32767, -32767, 1'b0);             // exact negative correlation
    send_pair(-32767, 32767, 1'b0);
    send_pair(100, -100, 1'b1);
    send_pair(-32768, 32767, 1'b0);             // extremes, crossed
    send_pair(32767, -32768, 1'b0);
    send_pair(-1, 1, 1'b0);
    send_pair(21845, -21846, 1'b1);
    send_pair(7, 7, 1'b0);                      // flat second series
    send_pair(-7, 7, 1'b1);
    send_pair(-32768, -1, 1'b0);                // two pairs, exact positive correlation
    send_pair(32767, 0, 1'b1);
  endtask

  task automatic random_windows(int budget);
    int r, len;
    mix_t mix;
    while (sent < budget) begin
      r   = $urandom_range(0, 99);
      len = (r < 70) ? $urandom_range(1, 12) :
            (r < 95) ? $urandom_range(13, 80) : $urandom_range(81, 300);
      mix = mix_t'($urandom_range(0, 9) < 6 ? $urandom_range(0, 1) : $urandom_range(0, 3));
      burst = ($urandom_range(0, 4) == 0);
      send_window(len, mix, 1'b1);
    end
    burst = 1'b0;
  endtask

  // stimulus
  initial begin
    rst                 = 1'b1;
    cfg_write_en        = 1'b0;
    cfg_write_data      = 1'b0;
    samples.valid       = 1'b0;
    samples.sample_x    = '0;
    samples.sample_y    = '0;
    samples.last_sample = 1'b0;
    sent         = 0;
    burst        = 1'b0;
    squeeze_req  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_windows();
    write_mode(1'b1);
    directed_windows();
    squeeze_req = 1'b1;
    random_windows(500);
    write_mode(1'b0);
    random_windows(1000);
    write_mode(1'b1);
    send_window(5, MIX_INDEP, 1'b1);
    samples.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side readiness, with one long hold-off
  initial begin
    int g;
    results.ready = 1'b0;
    squeeze_done  = 1'b0;
    wait (!rst);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        results.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        g = burst ? 0 : pick_gap();
        if (g == 0) begin
          results.ready <= 1'b1;
          @(posedge clk);
        end else begin
          results.ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((samples.valid && samples.ready) || (results.valid && results.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/wpc_pkg.sv
rtl/wpc_if.sv
rtl/wpc_front.sv
rtl/wpc_queue.sv
rtl/wpc_back.sv
rtl/windowed_pearson_correlation.sv
verif/wpc_checker.sv
verif/testbench.sv
